FILE: hdl/pcpa_pkg.sv
// Shared types, codes and default constants for the per-CPU page allocator.
// No dependencies; imported by the controller, the datapath and the top module.
package pcpa_pkg;

	localparam int NUM_CPUS_DEF   = 8;
	localparam int MAX_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [31:0] KERNEL_END_RESET = 32'd2148532224;
	localparam logic [31:0] MEMORY_TOP_RESET = 32'd2281701376;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REBUILD = 2'd2;

	localparam logic [1:0] RSP_OK       = 2'd0;
	localparam logic [1:0] RSP_NO_PAGE  = 2'd1;
	localparam logic [1:0] RSP_BAD_ADDR = 2'd2;

	localparam logic REG_KERNEL_END = 1'b0;
	localparam logic REG_MEMORY_TOP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_POP,
		ST_RB_DIV_START,
		ST_RB_DIV,
		ST_RB_PUSH,
		ST_RESP
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_SCAN_NEXT,
		DP_POP_READ,
		DP_POP_DONE,
		DP_NO_PAGE,
		DP_FREE,
		DP_RB_INIT,
		DP_RB_DIV,
		DP_RB_SETUP,
		DP_RB_PUSH,
		DP_RB_NEXT,
		DP_DONE_OK,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		logic [1:0] req_cmd;
		logic       head_ok;
		logic       scan_last;
		logic       div_busy;
		logic       push_more;
		logic       cpu_last;
		logic       out_free;
	} dp_stat_t;

endpackage

FILE: hdl/pcpa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/pcpa_div.sv
// Restoring divider, one quotient bit per cycle, for the rebuild share split.
// No dependencies.
module pcpa_div #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	assign rem_sh   = {rem_q, quo_q[DVD_W-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

FILE: hdl/pcpa_datapath.sv
// Datapath: config registers, list heads, next-page table, share divider, result registers.
// Depends on pcpa_pkg, pcpa_ram and pcpa_div.
module pcpa_datapath import pcpa_pkg::*; #(
	parameter int NUM_CPUS   = NUM_CPUS_DEF,
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_op_t      op,
	output dp_stat_t    stat,
	input  logic [1:0]  cmd,
	input  logic [2:0]  cpu_number,
	input  logic [31:0] page_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [31:0] granted_address
);

	localparam int SHIFT     = $clog2(PAGE_BYTES);
	localparam int ADDR_PG_W = 32 - SHIFT;
	localparam int PG_W      = ADDR_PG_W + 1;
	localparam int LINK_W    = $clog2(MAX_PAGES + 1);
	localparam int IDX_W     = $clog2(MAX_PAGES);
	localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int DVS_W     = $clog2(NUM_CPUS + 1);
	localparam logic [PG_W-1:0] BASE_RST =
		PG_W'((64'(KERNEL_END_RESET) + 64'(PAGE_BYTES) - 64'd1) >> SHIFT);
	localparam logic [PG_W-1:0]   MAX_PG   = PG_W'(MAX_PAGES);
	localparam logic [LINK_W-1:0] MAX_LINK = LINK_W'(MAX_PAGES);
	localparam logic [CPU_W-1:0]  CPU_LAST = CPU_W'(NUM_CPUS - 1);

	logic [31:0]       kend_q, top_q;
	logic [PG_W-1:0]   base_q, start_q;
	logic [LINK_W-1:0] head_q [NUM_CPUS];
	logic [CPU_W-1:0]  sel_q, scan_q;
	logic [1:0]        req_cmd_q;
	logic [31:0]       pa_q;
	logic [LINK_W-1:0] pop_idx_q, cur_q, end_q;
	logic [1:0]        res_status_q;
	logic [31:0]       res_addr_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [31:0]       out_addr_q;

	logic [CPU_W-1:0]  cpu_mod, sel_next;
	logic [3:0]        mod_v;
	logic [LINK_W-1:0] head_sel;
	logic [PG_W-1:0]   rb_base, first_pg, count_pg, pa_diff;
	logic [PG_W:0]     end_sum;
	logic [PG_W:0]     start_bytes_hi;
	logic [32:0]       start_bytes;
	logic              start_lt_top;
	logic [31:0]       div_dvd, div_quo;
	logic [32:0]       quo_round;
	logic              div_busy;
	logic [DVS_W-1:0]  div_dvs;
	logic              free_bad, free_push;
	logic [ADDR_PG_W-1:0] grant_pg;
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr;
	logic [LINK_W-1:0] ram_rdata;

	always_comb begin
		mod_v = {1'b0, cpu_number};
		for (int i = 0; i < 8; i++) begin
			if (mod_v >= 4'(NUM_CPUS)) begin
				mod_v = mod_v - 4'(NUM_CPUS);
			end
		end
		cpu_mod = CPU_W'(mod_v);
	end

	assign head_sel = head_q[sel_q];
	assign sel_next = (sel_q == CPU_LAST) ? '0 : sel_q + 1'b1;

	assign rb_base        = PG_W'(({1'b0, kend_q} + 33'(PAGE_BYTES - 1)) >> SHIFT);
	assign start_bytes_hi = {1'b0, start_q};
	assign start_bytes    = 33'({start_bytes_hi, {SHIFT{1'b0}}});
	assign start_lt_top   = start_bytes < {1'b0, top_q};
	assign div_dvd        = start_lt_top ? top_q - start_bytes[31:0] : '0;
	assign div_dvs        = DVS_W'(NUM_CPUS) - DVS_W'(sel_q);
	assign quo_round      = {1'b0, div_quo} + 33'(PAGE_BYTES - 1);
	assign count_pg       = PG_W'(quo_round >> SHIFT);
	assign first_pg       = start_q - base_q;
	assign end_sum        = {1'b0, first_pg} + {1'b0, count_pg};

	assign free_bad = (pa_q[SHIFT-1:0] != '0) || (pa_q < kend_q) || (pa_q >= top_q);
	assign pa_diff  = {1'b0, pa_q[31:SHIFT]} - base_q;
	assign free_push = !free_bad && ({1'b0, pa_q[31:SHIFT]} >= base_q) && (pa_diff < MAX_PG);

	assign grant_pg = base_q[ADDR_PG_W-1:0] + ADDR_PG_W'(pop_idx_q);

	assign ram_re    = op == DP_POP_READ;
	assign ram_we    = (op == DP_FREE && free_push) || (op == DP_RB_PUSH && cur_q < end_q);
	assign ram_waddr = (op == DP_FREE) ? IDX_W'(pa_diff) : IDX_W'(cur_q);

	pcpa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_PAGES)
	) u_next_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(head_sel),
		.re   (ram_re),
		.raddr(IDX_W'(head_sel - 1'b1)),
		.rdata(ram_rdata)
	);

	pcpa_div #(
		.DVD_W(32),
		.DVS_W(DVS_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (op == DP_RB_DIV),
		.dividend(div_dvd),
		.divisor (div_dvs),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	always_comb begin
		stat.req_cmd   = req_cmd_q;
		stat.head_ok   = (head_sel != '0) && (head_sel <= MAX_LINK);
		stat.scan_last = scan_q == CPU_LAST;
		stat.div_busy  = div_busy;
		stat.push_more = cur_q < end_q;
		stat.cpu_last  = sel_q == CPU_LAST;
		stat.out_free  = !out_valid_q || rsp_ready;
	end

	assign cfg_ready       = 1'b1;
	assign rsp_valid       = out_valid_q;
	assign status          = out_status_q;
	assign granted_address = out_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q      <= KERNEL_END_RESET;
			top_q       <= MEMORY_TOP_RESET;
			base_q      <= BASE_RST;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_KERNEL_END: kend_q <= cfg_data;
					REG_MEMORY_TOP: top_q  <= cfg_data;
					default: ;
				endcase
			end
			if (op == DP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				DP_POP_DONE: head_q[sel_q] <= ram_rdata;
				DP_FREE: begin
					if (free_push) begin
						head_q[sel_q] <= LINK_W'(pa_diff) + 1'b1;
					end
				end
				DP_RB_INIT: begin
					base_q <= rb_base;
					for (int i = 0; i < NUM_CPUS; i++) begin
						head_q[i] <= '0;
					end
				end
				DP_RB_PUSH: begin
					if (cur_q < end_q) begin
						head_q[sel_q] <= cur_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			DP_LOAD: begin
				req_cmd_q <= cmd;
				pa_q      <= page_address;
				sel_q     <= cpu_mod;
				scan_q    <= '0;
			end
			DP_SCAN_NEXT: begin
				sel_q  <= sel_next;
				scan_q <= scan_q + 1'b1;
			end
			DP_POP_READ: pop_idx_q <= head_sel - 1'b1;
			DP_POP_DONE: begin
				res_status_q <= RSP_OK;
				res_addr_q   <= {grant_pg, {SHIFT{1'b0}}};
			end
			DP_NO_PAGE: begin
				res_status_q <= RSP_NO_PAGE;
				res_addr_q   <= '0;
			end
			DP_FREE: begin
				res_status_q <= free_bad ? RSP_BAD_ADDR : RSP_OK;
				res_addr_q   <= '0;
			end
			DP_RB_INIT: begin
				start_q <= rb_base;
				sel_q   <= '0;
			end
			DP_RB_SETUP: begin
				cur_q   <= (first_pg >= MAX_PG) ? MAX_LINK : LINK_W'(first_pg);
				end_q   <= (end_sum >= {1'b0, MAX_PG}) ? MAX_LINK : LINK_W'(end_sum);
				start_q <= start_q + count_pg;
			end
			DP_RB_PUSH: begin
				if (cur_q < end_q) begin
					cur_q <= cur_q + 1'b1;
				end
			end
			DP_RB_NEXT: sel_q <= sel_q + 1'b1;
			DP_DONE_OK: begin
				res_status_q <= RSP_OK;
				res_addr_q   <= '0;
			end
			DP_EMIT: begin
				out_status_q <= res_status_q;
				out_addr_q   <= res_addr_q;
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/pcpa_ctrl.sv
// Controller state machine: sequences alloc scan, free, rebuild and result handoff.
// Depends on pcpa_pkg.
module pcpa_ctrl import pcpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output dp_op_t   op
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = DP_NOP;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					op      = DP_LOAD;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (stat.req_cmd)
					CMD_ALLOC: state_d = ST_SCAN;
					CMD_FREE: begin
						op      = DP_FREE;
						state_d = ST_RESP;
					end
					CMD_REBUILD: begin
						op      = DP_RB_INIT;
						state_d = ST_RB_DIV_START;
					end
					default: begin
						op      = DP_DONE_OK;
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN: begin
				if (stat.head_ok) begin
					op      = DP_POP_READ;
					state_d = ST_POP;
				end else if (stat.scan_last) begin
					op      = DP_NO_PAGE;
					state_d = ST_RESP;
				end else begin
					op = DP_SCAN_NEXT;
				end
			end
			ST_POP: begin
				op      = DP_POP_DONE;
				state_d = ST_RESP;
			end
			ST_RB_DIV_START: begin
				op      = DP_RB_DIV;
				state_d = ST_RB_DIV;
			end
			ST_RB_DIV: begin
				if (!stat.div_busy) begin
					op      = DP_RB_SETUP;
					state_d = ST_RB_PUSH;
				end
			end
			ST_RB_PUSH: begin
				if (stat.push_more) begin
					op = DP_RB_PUSH;
				end else if (stat.cpu_last) begin
					op      = DP_DONE_OK;
					state_d = ST_RESP;
				end else begin
					op      = DP_RB_NEXT;
					state_d = ST_RB_DIV_START;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					op      = DP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hdl/per_cpu_page_free_list_allocator.sv
// Per-CPU page free-list allocator with stealing: controller plus datapath.
// An alloc probes k list heads (1..NUM_CPUS), one per cycle, and answers no page when all
// NUM_CPUS lists are empty; a rebuild runs the bit-serial share divider once per CPU and pushes
// one page per cycle. One request at a time; the next is taken the cycle after the response is
// loaded, even while it waits in the output register. Reset empties all lists and latches the
// page-rounded default kernel end; the table is not cleared.
module per_cpu_page_free_list_allocator import pcpa_pkg::*; #(
	parameter int NUM_CPUS   = NUM_CPUS_DEF,
	parameter int MAX_PAGES  = MAX_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [2:0]  cpu_number,
	input  logic [31:0] page_address,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  status,
	output logic [31:0] granted_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	dp_op_t   op;
	dp_stat_t stat;

	pcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.stat     (stat),
		.op       (op)
	);

	pcpa_datapath #(
		.NUM_CPUS  (NUM_CPUS),
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.stat           (stat),
		.cmd            (cmd),
		.cpu_number     (cpu_number),
		.page_address   (page_address),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.status         (status),
		.granted_address(granted_address)
	);

endmodule
